// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define RPHD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RPHD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/rphd_pkg.sv =====
package rphd_pkg;

    localparam int SPEED_W = 16;
    localparam int TICKS_W = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Elapsed counter value that means no peak is being shown
    localparam logic [SPEED_W-1:0] ELAPSED_IDLE = 16'hFFFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_HYST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_HYST = 3'd4;

    typedef struct packed {
        logic               feature_enable;
        logic [TICKS_W-1:0] display_ticks;
        logic [SPEED_W-1:0] speed_threshold;
        logic [SPEED_W-1:0] display_hysteresis;
        logic [SPEED_W-1:0] noise_hysteresis;
    } cfg_t;

    // History memory control from the sequencer
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clr_all;
    } mem_ctl_t;

endpackage

// ===== design/rphd_hist_mem.sv =====
module rphd_hist_mem
    import rphd_pkg::*;
#(
    parameter int DEPTH = 26,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  mem_ctl_t           ctl,
    input  logic [AW-1:0]      waddr,
    input  logic [SPEED_W-1:0] wdata,
    input  logic [AW-1:0]      raddr,
    output logic [SPEED_W-1:0] rd_val
);

    logic [SPEED_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]   vld_reg;
    logic [SPEED_W-1:0] rd_data_reg;
    logic               rd_vld_reg;

    // Store the beat sample
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[waddr] <= wdata;
        end
    end

    // Track written entries; a cleared entry reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clr_all) begin
            vld_reg <= '0;
        end else if (ctl.wr_en) begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data_reg <= mem[raddr];
            rd_vld_reg  <= vld_reg[raddr];
        end
    end

    assign rd_val = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ===== design/rphd_ctrl.sv =====
module rphd_ctrl
    import rphd_pkg::*;
#(
    parameter int DEPTH = 26,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_ignition,
    input  logic               in_invalid,
    input  logic [SPEED_W-1:0] in_speed,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_shown,
    output logic [SPEED_W-1:0] out_speed
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_START    = 4'd1;
    localparam logic [3:0] ST_DECIDE   = 4'd2;
    localparam logic [3:0] ST_SCAN_PK  = 4'd3;
    localparam logic [3:0] ST_PK_WAIT  = 4'd4;
    localparam logic [3:0] ST_BOT_INIT = 4'd5;
    localparam logic [3:0] ST_SCAN_BOT = 4'd6;
    localparam logic [3:0] ST_BOT_WAIT = 4'd7;
    localparam logic [3:0] ST_FINISH   = 4'd8;
    localparam logic [3:0] ST_EMIT     = 4'd9;

    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(DEPTH);

    logic [3:0]         state_reg, state_next;
    logic [SPEED_W-1:0] sample_reg, sample_next;
    logic               clr_reg, clr_next;
    logic [AW-1:0]      newest_reg, newest_next;
    logic [AW-1:0]      peak_slot_reg, peak_slot_next;
    logic [SPEED_W-1:0] peak_val_reg, peak_val_next;
    logic [SPEED_W-1:0] bottom_reg, bottom_next;
    logic [SPEED_W-1:0] elapsed_reg, elapsed_next;
    logic [SPEED_W-1:0] shown_reg, shown_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      cnt_reg, cnt_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic               cmp_bot_reg, cmp_bot_next;
    logic [AW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_shown_reg, out_shown_next;
    logic [SPEED_W-1:0] out_speed_reg, out_speed_next;

    mem_ctl_t           mem_ctl;
    logic [AW-1:0]      mem_raddr;
    logic [SPEED_W-1:0] rd_val;

    logic [AW-1:0]      base_slot;
    logic [AW:0]        span;
    logic [SPEED_W-1:0] elapsed_inc;
    logic [SPEED_W:0]   drop_diff;
    logic [SPEED_W:0]   rise_diff;
    logic               show_ok;
    logic               in_window;

    rphd_hist_mem #(.DEPTH(DEPTH)) u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mem_ctl),
        .waddr   (newest_reg),
        .wdata   (sample_reg),
        .raddr   (mem_raddr),
        .rd_val  (rd_val)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_shown = out_shown_reg;
    assign out_speed = out_speed_reg;

    // Bottom scan runs from the oldest entry up to the peak
    always_comb begin
        base_slot = (newest_reg == LAST_SLOT) ? '0 : newest_reg + 1'b1;
        if (peak_slot_reg >= base_slot) begin
            span = {1'b0, peak_slot_reg} - {1'b0, base_slot};
        end else begin
            span = DEPTH_W - {1'b0, base_slot} + {1'b0, peak_slot_reg};
        end
    end

    // Display decision; differences are signed
    always_comb begin
        elapsed_inc = (elapsed_reg != ELAPSED_IDLE) ? elapsed_reg + 1'b1 : elapsed_reg;
        in_window   = (elapsed_inc <= {4'd0, cfg.display_ticks});
        drop_diff   = {1'b0, peak_val_reg} - {1'b0, sample_reg};
        rise_diff   = {1'b0, peak_val_reg} - {1'b0, bottom_reg};
        show_ok     = (sample_reg >= cfg.speed_threshold)
                   && !drop_diff[SPEED_W] && (drop_diff[SPEED_W-1:0] >= cfg.display_hysteresis)
                   && !rise_diff[SPEED_W] && (rise_diff[SPEED_W-1:0] >= cfg.noise_hysteresis);
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        sample_next    = sample_reg;
        clr_next       = clr_reg;
        newest_next    = newest_reg;
        peak_slot_next = peak_slot_reg;
        peak_val_next  = peak_val_reg;
        bottom_next    = bottom_reg;
        elapsed_next   = elapsed_reg;
        shown_next     = shown_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        cmp_vld_next   = 1'b0;
        cmp_bot_next   = cmp_bot_reg;
        cmp_idx_next   = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_shown_next = out_shown_reg;
        out_speed_next = out_speed_reg;
        mem_ctl        = '0;
        mem_raddr      = idx_reg;

        // Fold in the read that was issued last cycle
        if (cmp_vld_reg) begin
            if (cmp_bot_reg) begin
                if (rd_val < bottom_reg) begin
                    bottom_next = rd_val;
                end
            end else if (rd_val >= peak_val_reg) begin
                peak_val_next  = rd_val;
                peak_slot_next = cmp_idx_reg;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    sample_next = in_invalid ? '0 : in_speed;
                    clr_next    = !in_ignition || !cfg.feature_enable;
                    state_next  = ST_START;
                end
            end
            ST_START: begin
                if (clr_reg) begin
                    mem_ctl.clr_all = 1'b1;
                    newest_next     = '0;
                    peak_slot_next  = '0;
                    bottom_next     = '0;
                    elapsed_next    = ELAPSED_IDLE;
                    shown_next      = '0;
                    state_next      = ST_EMIT;
                end else begin
                    mem_ctl.rd_en = 1'b1;
                    mem_raddr     = peak_slot_reg;
                    state_next    = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                // Old peak is on the read port; store the sample
                mem_ctl.wr_en = 1'b1;
                if ((sample_reg > rd_val) || (newest_reg == peak_slot_reg)) begin
                    peak_val_next = '0;
                    idx_next      = '0;
                    state_next    = ST_SCAN_PK;
                end else begin
                    peak_val_next = rd_val;
                    state_next    = ST_FINISH;
                end
            end
            ST_SCAN_PK: begin
                mem_ctl.rd_en = 1'b1;
                cmp_vld_next  = 1'b1;
                cmp_bot_next  = 1'b0;
                idx_next      = idx_reg + 1'b1;
                if (idx_reg == LAST_SLOT) begin
                    state_next = ST_PK_WAIT;
                end
            end
            ST_PK_WAIT: begin
                state_next = ST_BOT_INIT;
            end
            ST_BOT_INIT: begin
                idx_next = base_slot;
                cnt_next = span[AW-1:0];
                state_next = (span == '0) ? ST_FINISH : ST_SCAN_BOT;
            end
            ST_SCAN_BOT: begin
                mem_ctl.rd_en = 1'b1;
                cmp_vld_next  = 1'b1;
                cmp_bot_next  = 1'b1;
                idx_next      = (idx_reg == LAST_SLOT) ? '0 : idx_reg + 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == AW'(1)) begin
                    state_next = ST_BOT_WAIT;
                end
            end
            ST_BOT_WAIT: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                priority if (in_window) begin
                    if (sample_reg > shown_reg) begin
                        elapsed_next = ELAPSED_IDLE;
                        shown_next   = '0;
                    end else begin
                        elapsed_next = elapsed_inc;
                    end
                end else if (show_ok) begin
                    elapsed_next = '0;
                    shown_next   = peak_val_reg;
                    bottom_next  = peak_val_reg;
                end else begin
                    elapsed_next = elapsed_inc;
                    shown_next   = '0;
                end
                newest_next = (newest_reg == LAST_SLOT) ? '0 : newest_reg + 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready) begin
                    out_valid_next = 1'b1;
                    out_shown_next = (elapsed_reg <= {4'd0, cfg.display_ticks});
                    out_speed_next = out_shown_next ? shown_reg : '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and block state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            newest_reg    <= '0;
            peak_slot_reg <= '0;
            bottom_reg    <= '0;
            elapsed_reg   <= ELAPSED_IDLE;
            shown_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            newest_reg    <= newest_next;
            peak_slot_reg <= peak_slot_next;
            bottom_reg    <= bottom_next;
            elapsed_reg   <= elapsed_next;
            shown_reg     <= shown_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working payload
    always_ff @(posedge aclk) begin
        sample_reg    <= sample_next;
        clr_reg       <= clr_next;
        peak_val_reg  <= peak_val_next;
        idx_reg       <= idx_next;
        cnt_reg       <= cnt_next;
        cmp_bot_reg   <= cmp_bot_next;
        cmp_idx_reg   <= cmp_idx_next;
        out_shown_reg <= out_shown_next;
        out_speed_reg <= out_speed_next;
    end

endmodule

// ===== design/rpm_peak_hold_detector_core.sv =====
// Engine speed peak-hold detector. Each input beat is one 20 ms tick and
// yields exactly one output beat (peak shown flag in m_tuser, peak speed in
// m_tdata). The speed history lives in a single-port-read memory of
// HISTORY_DEPTH entries with a registered read port, so a tick that forces
// a peak rescan walks the whole history for the maximum and then walks from
// the oldest entry up to the peak for the bottom. A tick with ignition off or
// the feature disabled clears all history at once. One tick is processed at
// a time; a finished result may wait in the output register while the next
// tick is accepted. Configuration writes are only allowed while the block is
// idle; the user must keep to this, as the block itself does not enforce it.
`include "assert_macros.svh"

module rpm_peak_hold_detector_core
    import rphd_pkg::*;
#(
    parameter int HISTORY_DEPTH = 26
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Tick input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // [0] ignition_on, [16:1] engine_speed
    input  logic                  s_tuser,   // [0] sample_invalid
    // Result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [15:0] peak_speed
    output logic                  m_tuser    // [0] peak_shown
);

    cfg_t cfg_reg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.feature_enable     <= 1'b0;
            cfg_reg.display_ticks      <= '0;
            cfg_reg.speed_threshold    <= '1;
            cfg_reg.display_hysteresis <= '1;
            cfg_reg.noise_hysteresis   <= '1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FEATURE_ENABLE:  cfg_reg.feature_enable     <= cfg_wdata[0];
                CFG_DISPLAY_TICKS:   cfg_reg.display_ticks      <= cfg_wdata[TICKS_W-1:0];
                CFG_SPEED_THRESHOLD: cfg_reg.speed_threshold    <= cfg_wdata;
                CFG_DISPLAY_HYST:    cfg_reg.display_hysteresis <= cfg_wdata;
                CFG_NOISE_HYST:      cfg_reg.noise_hysteresis   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    rphd_ctrl #(.DEPTH(HISTORY_DEPTH)) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_ignition (s_tdata[0]),
        .in_invalid  (s_tuser),
        .in_speed    (s_tdata[16:1]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_shown   (m_tuser),
        .out_speed   (m_tdata)
    );

    `RPHD_ASSERT(a_one_beat_in_flight, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "second tick accepted while busy")
    `RPHD_ASSERT(a_disabled_not_shown, aclk, aresetn, (m_tvalid && !cfg_reg.feature_enable) |-> (!m_tuser && (m_tdata == '0)), "peak shown while feature disabled")
    `RPHD_ASSERT_ALWAYS(a_reset_no_result, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule
